// ===== rtl/core/lfu_pkg.sv =====
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared constants and types for the LFU cache table.
// ----------------------------------------------------------------------------
package lfu_pkg;
  localparam int unsigned EntriesDef   = 16;
  localparam int unsigned CountBitsDef = 16;
  localparam int unsigned KeyW         = 32;
  localparam int unsigned ValW         = 32;
  localparam int unsigned CapW         = 5;

  localparam logic OpGet = 1'b0;
  localparam logic OpPut = 1'b1;

  typedef struct packed {
    logic start;    // latch item, clear scan state
    logic scan;     // examine entry at scan index
    logic commit;   // apply update for the item
    logic rank;     // age one entry's rank at scan index
    logic finish;   // load output register
  } lfu_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic do_update;  // commit selects a slot to make most recent
  } lfu_sts_t;
endpackage

// ===== rtl/core/lfu_req_if.sv =====
// ----------------------------------------------------------------------------
// lfu_req_if
// Request channel: op, key and value.
// ----------------------------------------------------------------------------
interface lfu_req_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [31:0]        lookup_key;
  logic signed [31:0] write_value;
  modport source (output valid, op, lookup_key, write_value, input ready);
  modport sink   (input valid, op, lookup_key, write_value, output ready);
endinterface

// ===== rtl/core/lfu_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lfu_rsp_if
// Response channel: found, read value, evicted.
// ----------------------------------------------------------------------------
interface lfu_rsp_if;
  logic               valid;
  logic               ready;
  logic               found;
  logic signed [31:0] read_value;
  logic               evicted;
  modport source (output valid, found, read_value, evicted, input ready);
  modport sink   (input valid, found, read_value, evicted, output ready);
endinterface

// ===== rtl/core/lfu_ctrl.sv =====
// ----------------------------------------------------------------------------
// lfu_ctrl
// Sequencer: lookup scan, commit, rank-aging scan, response.
// ----------------------------------------------------------------------------
module lfu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_busy_i,
  input  lfu_pkg::lfu_sts_t sts_i,
  output lfu_pkg::lfu_cmd_t cmd_o
);
  import lfu_pkg::*;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StScan   = 3'd1;
  localparam logic [2:0] StCommit = 3'd2;
  localparam logic [2:0] StRank   = 3'd3;
  localparam logic [2:0] StDone   = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = StScan;
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) state_d = StCommit;
      end
      StCommit: begin
        cmd_o.commit = 1'b1;
        state_d      = sts_i.do_update ? StRank : StDone;
      end
      StRank: begin
        cmd_o.rank = 1'b1;
        if (sts_i.scan_last) state_d = StDone;
      end
      StDone: begin
        if (!out_busy_i) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end
endmodule

// ===== rtl/core/lfu_dp.sv =====
// ----------------------------------------------------------------------------
// lfu_dp
// Entry store and scan datapath: key match, victim search, update, aging.
// ----------------------------------------------------------------------------
module lfu_dp #(
  parameter int unsigned Entries   = lfu_pkg::EntriesDef,
  parameter int unsigned CountBits = lfu_pkg::CountBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lfu_pkg::lfu_cmd_t        cmd_i,
  output lfu_pkg::lfu_sts_t        sts_o,
  input  logic [lfu_pkg::CapW-1:0] cap_i,
  input  logic                     op_i,
  input  logic [31:0]              key_i,
  input  logic signed [31:0]       wval_i,
  output logic                     found_o,
  output logic signed [31:0]       rval_o,
  output logic                     evicted_o
);
  import lfu_pkg::*;

  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned UseW = $clog2(Entries + 1);
  localparam logic [CountBits-1:0] CntMax = '1;
  localparam logic [IdxW-1:0] IdxLast = IdxW'(Entries - 1);

  logic [Entries-1:0]   valid_q;
  logic [KeyW-1:0]      key_mem  [Entries];
  logic [ValW-1:0]      val_mem  [Entries];
  logic [CountBits-1:0] cnt_mem  [Entries];
  logic [IdxW-1:0]      rank_mem [Entries];

  logic                 op_q;
  logic [KeyW-1:0]      key_q;
  logic [ValW-1:0]      wval_q;
  logic [IdxW-1:0]      idx_q;
  logic [UseW-1:0]      used_q;
  logic                 hit_q, free_q, vic_q;
  logic [IdxW-1:0]      hit_idx_q, free_idx_q, vic_idx_q;
  logic [CountBits-1:0] vic_cnt_q;
  logic [IdxW-1:0]      vic_rank_q;
  logic [IdxW-1:0]      sel_q;       // slot made most recent
  logic [UseW-1:0]      old_q;       // its previous rank (or fill)
  logic                 found_q, ev_q;
  logic [ValW-1:0]      rval_q;

  logic                 cur_v;
  logic [CountBits-1:0] cur_cnt;
  logic [IdxW-1:0]      cur_rank;
  logic                 better;
  logic [UseW-1:0]      cap_sat;
  logic                 full;

  assign cur_v    = valid_q[idx_q];
  assign cur_cnt  = cnt_mem[idx_q];
  assign cur_rank = rank_mem[idx_q];
  assign better   = !vic_q || (cur_cnt < vic_cnt_q) ||
                    (cur_cnt == vic_cnt_q && cur_rank > vic_rank_q);
  assign cap_sat  = (32'(cap_i) > Entries) ? UseW'(Entries) : UseW'(cap_i);
  assign full     = used_q >= cap_sat;

  assign sts_o.scan_last = (idx_q == IdxLast);
  assign sts_o.do_update = hit_q || (op_q == OpPut && cap_sat != '0 &&
                           ((full && vic_q) || free_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= '0;
    else if (cmd_i.commit && !hit_q && sts_o.do_update)
      valid_q[(full && vic_q) ? vic_idx_q : free_idx_q] <= 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q <= op_i; key_q <= key_i; wval_q <= wval_i;
      idx_q <= '0; used_q <= '0;
      hit_q <= 1'b0; free_q <= 1'b0; vic_q <= 1'b0;
      found_q <= 1'b0; ev_q <= 1'b0; rval_q <= '0;
    end
    if (cmd_i.scan) begin
      if (cur_v) begin
        used_q <= used_q + 1'b1;
        if (!hit_q && key_mem[idx_q] == key_q) begin
          hit_q <= 1'b1; hit_idx_q <= idx_q;
        end
        if (better) begin
          vic_q <= 1'b1; vic_idx_q <= idx_q;
          vic_cnt_q <= cur_cnt; vic_rank_q <= cur_rank;
        end
      end else if (!free_q) begin
        free_q <= 1'b1; free_idx_q <= idx_q;
      end
      idx_q <= sts_o.scan_last ? '0 : idx_q + 1'b1;
    end
    if (cmd_i.commit) begin
      if (hit_q) begin
        found_q <= 1'b1;
        if (op_q == OpGet) rval_q <= val_mem[hit_idx_q];
        else val_mem[hit_idx_q] <= wval_q;
        if (cnt_mem[hit_idx_q] != CntMax)
          cnt_mem[hit_idx_q] <= cnt_mem[hit_idx_q] + 1'b1;
        sel_q <= hit_idx_q;
        old_q <= UseW'(rank_mem[hit_idx_q]);
      end else if (sts_o.do_update) begin
        if (full && vic_q) begin
          ev_q <= 1'b1;
          sel_q <= vic_idx_q; old_q <= UseW'(vic_rank_q);
          key_mem[vic_idx_q] <= key_q; val_mem[vic_idx_q] <= wval_q;
          cnt_mem[vic_idx_q] <= CountBits'(1);
        end else begin
          sel_q <= free_idx_q; old_q <= used_q;
          key_mem[free_idx_q] <= key_q; val_mem[free_idx_q] <= wval_q;
          cnt_mem[free_idx_q] <= CountBits'(1);
        end
      end
    end
    // aging pass; valid_q already includes a newly filled slot
    if (cmd_i.rank) begin
      if (idx_q == sel_q) rank_mem[idx_q] <= '0;
      else if (cur_v && UseW'(cur_rank) < old_q) rank_mem[idx_q] <= cur_rank + 1'b1;
      idx_q <= sts_o.scan_last ? '0 : idx_q + 1'b1;
    end
  end

  assign found_o   = found_q;
  assign rval_o    = rval_q;
  assign evicted_o = ev_q;
endmodule

// ===== rtl/core/lfu_cache_table_unit.sv =====
// An item runs a lookup scan that reads one entry per cycle, then a commit
// step, then, when it updates an entry, a rank-aging scan over the
// single-ported entry store; a miss that changes nothing skips the aging
// scan. The result sits in an output register, so the next item is accepted
// once it is loaded. The table resets empty.
// ----------------------------------------------------------------------------
// lfu_cache_table_unit
// LFU key/value cache with LRU tie break, sequential scan datapath.
// ----------------------------------------------------------------------------
module lfu_cache_table_unit #(
  parameter int unsigned Entries   = lfu_pkg::EntriesDef,
  parameter int unsigned CountBits = lfu_pkg::CountBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [lfu_pkg::CapW-1:0] cfg_wdata_i,
  lfu_req_if.sink                  req,
  lfu_rsp_if.source                rsp
);
  import lfu_pkg::*;

  lfu_cmd_t        cmd;
  lfu_sts_t        sts;
  logic [CapW-1:0] cap_q;
  logic            out_v_q;
  logic            found, evicted;
  logic [ValW-1:0] rval;
  logic            found_q, evicted_q;
  logic [ValW-1:0] rval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cap_q <= CapW'(16);
    else if (cfg_we_i) cap_q <= cfg_wdata_i;
  end

  lfu_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (req.valid),
    .in_ready_o (req.ready),
    .out_busy_i (out_v_q && !rsp.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lfu_dp #(.Entries(Entries), .CountBits(CountBits)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i (cmd), .sts_o (sts), .cap_i (cap_q),
    .op_i (req.op), .key_i (req.lookup_key), .wval_i (req.write_value),
    .found_o (found), .rval_o (rval), .evicted_o (evicted)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (cmd.finish) out_v_q <= 1'b1;
    else if (rsp.ready) out_v_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd.finish) begin
      found_q <= found; evicted_q <= evicted; rval_q <= rval;
    end
  end

  assign rsp.valid      = out_v_q;
  assign rsp.found      = found_q;
  assign rsp.read_value = rval_q;
  assign rsp.evicted    = evicted_q;

  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (!out_v_q || rsp.ready)) else $error("response overwritten");
  a_ev_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && rsp.evicted) |-> !rsp.found) else $error("evict on hit");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd)) else $error("overlapping commands");
endmodule
